/* rtl/core/prr_pkg.sv */
// Shared constants for the piano roll rasterizer.
package prr_pkg;

    localparam int MAX_STEPS  = 1024;
    localparam int PITCH_SPAN = 256;
    localparam int ROW_W      = $clog2(MAX_STEPS);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_SPU  = 1'b0;
    localparam logic CFG_DROP = 1'b1;

    localparam logic [6:0] SPU_RESET = 7'd4;
    localparam logic [7:0] LOW_RESET = 8'd127;

endpackage

/* rtl/core/piano_roll_rasterizer.sv */
// Piano roll rasterizer: note bitmap in a row memory, add / read / clear ops.
//
//  channel | signals                                   | dir | handshake
//  in      | op, note_pitch, beat_*, sec_*, row/word   | in  | in_valid / in_ready
//  out     | row_bits, time_steps, pitch_count, ...    | out | out_valid / out_ready
//  cfg     | cfg_index, cfg_data                       | in  | cfg_we, no wait
//
// One word in flight at a time. Add: a row-span step, then one memory read and
// one write per covered row through the single row memory. Read: a memory read,
// then the slice is latched. Clear: a sweep of all 1024 rows. Reset runs the same
// sweep with in_ready low. A finished word sits in the output register, so
// the next word is taken while out_ready is low; a second result waits in
// the final state until the output register frees.
module piano_roll_rasterizer
    import prr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  note_pitch,
    input  logic [19:0] beat_onset,
    input  logic [19:0] beat_length,
    input  logic [19:0] sec_onset,
    input  logic [19:0] sec_length,
    input  logic [9:0]  row_index,
    input  logic [1:0]  word_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] row_bits,
    output logic [10:0] time_steps,
    output logic [8:0]  pitch_count,
    output logic [7:0]  lowest_pitch,
    output logic        no_notes,
    output logic        clipped,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_WRD  = 4'd3;
    localparam logic [3:0] S_WWR  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_RDD  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [ROW_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_op_reg, clr_op_next;
    logic [7:0]       pitch_reg, pitch_next;
    logic [19:0]      on_reg, on_next;
    logic [20:0]      end_reg, end_next;
    logic [9:0]       row_reg, row_next;
    logic [1:0]       word_reg, word_next;
    logic [ROW_W-1:0] t_reg, t_next;
    logic [ROW_W-1:0] last_reg, last_next;
    logic [6:0]       spu_reg, spu_next;
    logic             drop_reg, drop_next;
    logic             use_beats_reg, use_beats_next;
    logic             mode_chosen_reg, mode_chosen_next;
    logic [20:0]      latest_end_reg, latest_end_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       high_reg, high_next;
    logic             kept_reg, kept_next;
    logic             clip_reg, clip_next;
    logic [63:0]      bits_reg, bits_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      row_bits_reg, row_bits_next;
    logic [10:0]      time_steps_reg, time_steps_next;
    logic [8:0]       pitch_count_reg, pitch_count_next;
    logic [7:0]       lowest_reg, lowest_next;
    logic             no_notes_reg, no_notes_next;
    logic             clipped_reg, clipped_next;

    // row memory: one entry per time step, one bit per pitch
    logic [PITCH_SPAN-1:0] grid_mem [MAX_STEPS];
    logic [PITCH_SPAN-1:0] rdata_reg;
    logic                  mem_we;
    logic [ROW_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_raddr;
    logic [PITCH_SPAN-1:0] mem_wdata;

    logic [26:0] prod_on;
    logic [27:0] prod_end;
    logic [27:0] prod_steps;
    logic [28:0] steps_round;
    logic [20:0] steps_full;
    logic [10:0] steps_sat;
    logic [8:0]  read_base;
    logic [PITCH_SPAN-1:0] shifted;
    logic [63:0] read_calc;
    logic [9:0]  pos;
    logic        sel_beats;
    logic [19:0] sel_on;
    logic [19:0] sel_len;
    logic [20:0] sel_end;
    logic        out_free;

    assign prod_on     = on_reg * spu_reg;
    assign prod_end    = end_reg * spu_reg;
    assign prod_steps  = latest_end_reg * spu_reg;
    assign steps_round = {1'b0, prod_steps} + 29'd255;
    assign steps_full  = steps_round[28:8] + 21'd1;
    assign steps_sat   = (steps_full > 21'(MAX_STEPS)) ? 11'(MAX_STEPS) : steps_full[10:0];

    assign sel_beats = mode_chosen_reg ? use_beats_reg
                                       : ((beat_onset != '0) || (beat_length != '0));
    assign sel_on  = sel_beats ? beat_onset : sec_onset;
    assign sel_len = sel_beats ? beat_length : sec_length;
    assign sel_end = {1'b0, sel_on} + {1'b0, sel_len};

    assign read_base = {1'b0, low_reg} + {1'b0, word_reg, 6'd0};
    assign shifted   = rdata_reg >> read_base;

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < 64; b++)
        begin
            pos = {1'b0, read_base} + 10'(b);
            read_calc[b] = shifted[b] && (pos <= {2'b00, high_reg}) && kept_reg
                           && ({1'b0, row_reg} < 11'(MAX_STEPS));
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_op_next      = clr_op_reg;
        pitch_next       = pitch_reg;
        on_next          = on_reg;
        end_next         = end_reg;
        row_next         = row_reg;
        word_next        = word_reg;
        t_next           = t_reg;
        last_next        = last_reg;
        spu_next         = spu_reg;
        drop_next        = drop_reg;
        use_beats_next   = use_beats_reg;
        mode_chosen_next = mode_chosen_reg;
        latest_end_next  = latest_end_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        kept_next        = kept_reg;
        clip_next        = clip_reg;
        bits_next        = bits_reg;
        out_valid_next   = out_valid_reg;
        row_bits_next    = row_bits_reg;
        time_steps_next  = time_steps_reg;
        pitch_count_next = pitch_count_reg;
        lowest_next      = lowest_reg;
        no_notes_next    = no_notes_reg;
        clipped_next     = clipped_reg;
        mem_we           = 1'b0;
        mem_waddr        = t_reg;
        mem_wdata        = rdata_reg | (PITCH_SPAN'(1) << pitch_reg);
        mem_raddr        = (state_reg == S_RD) ? row_reg[ROW_W-1:0] : t_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPU:  spu_next  = cfg_data;
                CFG_DROP: drop_next = cfg_data[0];
                default:  ;
            endcase
        end

        case (state_reg)
            S_CLR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(MAX_STEPS - 1))
                    state_next = clr_op_reg ? S_FIN : S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pitch_next = note_pitch;
                    row_next   = row_index;
                    word_next  = word_index;
                    bits_next  = '0;
                    case (op)
                        OP_ADD:
                        begin
                            mode_chosen_next = 1'b1;
                            use_beats_next   = sel_beats;
                            if ((drop_reg && note_pitch[7])
                                || ({1'b0, note_pitch} >= 9'(PITCH_SPAN)))
                                state_next = S_FIN;
                            else
                            begin
                                on_next  = sel_on;
                                end_next = sel_end;
                                if (sel_end > latest_end_reg)
                                    latest_end_next = sel_end;
                                if (note_pitch < low_reg)
                                    low_next = note_pitch;
                                if (note_pitch > high_reg)
                                    high_next = note_pitch;
                                kept_next  = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        OP_READ:
                            state_next = S_RD;
                        OP_CLEAR:
                        begin
                            use_beats_next   = 1'b0;
                            mode_chosen_next = 1'b0;
                            latest_end_next  = '0;
                            low_next         = LOW_RESET;
                            high_next        = '0;
                            kept_next        = 1'b0;
                            clip_next        = 1'b0;
                            clr_cnt_next     = '0;
                            clr_op_next      = 1'b1;
                            state_next       = S_CLR;
                        end
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_MUL:
            begin
                // row span of the note; rows past the store set the clip flag
                if (prod_end[27:8] >= 20'(MAX_STEPS))
                begin
                    clip_next = 1'b1;
                    last_next = ROW_W'(MAX_STEPS - 1);
                end
                else
                    last_next = prod_end[8 +: ROW_W];
                t_next = prod_on[8 +: ROW_W];
                if (prod_on[26:8] >= 19'(MAX_STEPS))
                    state_next = S_FIN;
                else
                    state_next = S_WRD;
            end
            S_WRD:
                state_next = S_WWR;
            S_WWR:
            begin
                mem_we = 1'b1;
                if (t_reg == last_reg)
                    state_next = S_FIN;
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_RD:
                state_next = S_RDD;
            S_RDD:
            begin
                bits_next  = read_calc;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    row_bits_next    = bits_reg;
                    time_steps_next  = kept_reg ? steps_sat : '0;
                    pitch_count_next = kept_reg ? ({1'b0, high_reg} - {1'b0, low_reg} + 9'd1)
                                                : '0;
                    lowest_next      = low_reg;
                    no_notes_next    = !kept_reg;
                    clipped_next     = clip_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= grid_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            clr_cnt_reg     <= '0;
            clr_op_reg      <= 1'b0;
            spu_reg         <= SPU_RESET;
            drop_reg        <= 1'b0;
            use_beats_reg   <= 1'b0;
            mode_chosen_reg <= 1'b0;
            latest_end_reg  <= '0;
            low_reg         <= LOW_RESET;
            high_reg        <= '0;
            kept_reg        <= 1'b0;
            clip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_op_reg      <= clr_op_next;
            spu_reg         <= spu_next;
            drop_reg        <= drop_next;
            use_beats_reg   <= use_beats_next;
            mode_chosen_reg <= mode_chosen_next;
            latest_end_reg  <= latest_end_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            kept_reg        <= kept_next;
            clip_reg        <= clip_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg       <= pitch_next;
        on_reg          <= on_next;
        end_reg         <= end_next;
        row_reg         <= row_next;
        word_reg        <= word_next;
        t_reg           <= t_next;
        last_reg        <= last_next;
        bits_reg        <= bits_next;
        row_bits_reg    <= row_bits_next;
        time_steps_reg  <= time_steps_next;
        pitch_count_reg <= pitch_count_next;
        lowest_reg      <= lowest_next;
        no_notes_reg    <= no_notes_next;
        clipped_reg     <= clipped_next;
    end

    assign out_valid    = out_valid_reg;
    assign row_bits     = row_bits_reg;
    assign time_steps   = time_steps_reg;
    assign pitch_count  = pitch_count_reg;
    assign lowest_pitch = lowest_reg;
    assign no_notes     = no_notes_reg;
    assign clipped      = clipped_reg;

    // memory is only written by the clear sweep or the row walk
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLR || state_reg == S_WWR))
        else $error("grid write outside sweep or walk");

    // row walk never runs past the last row of the note
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WWR) |-> (t_reg <= last_reg))
        else $error("row walk past note end");

    // an empty grid reports zero size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_notes) |-> (time_steps == '0 && pitch_count == '0 && row_bits == '0))
        else $error("empty grid with nonzero size");

    // a word waiting at the output is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(row_bits) && $stable(time_steps))
        else $error("output word overwritten while stalled");

endmodule

/* bench/tb_piano_roll_rasterizer.sv */
// Testbench for piano_roll_rasterizer: directed and random ops checked against a local model.
module tb_piano_roll_rasterizer;
    import prr_pkg::*;

    typedef struct packed {
        logic [63:0] row_bits;
        logic [10:0] time_steps;
        logic [8:0]  pitch_count;
        logic [7:0]  lowest_pitch;
        logic        no_notes;
        logic        clipped;
    } roll_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  note_pitch;
    logic [19:0] beat_onset;
    logic [19:0] beat_length;
    logic [19:0] sec_onset;
    logic [19:0] sec_length;
    logic [9:0]  row_index;
    logic [1:0]  word_index;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] row_bits;
    logic [10:0] time_steps;
    logic [8:0]  pitch_count;
    logic [7:0]  lowest_pitch;
    logic        no_notes;
    logic        clipped;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    piano_roll_rasterizer DUT (.*);

    // local copy of the roll state
    logic [63:0]  roll_grid [MAX_STEPS][4];
    logic         beats_mode;
    logic         mode_set;
    longint unsigned end_max;
    int unsigned  pitch_lo;
    int unsigned  pitch_hi;
    logic         any_kept;
    logic         clip_seen;
    logic [6:0]   spu;
    logic         drums_off;

    roll_word_t   expect_q[$];
    int           fail_cnt;
    bit           quiet;
    bit           hold_req;
    int unsigned  recent_row;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic clear_roll();
        for (int t = 0; t < MAX_STEPS; t++)
            for (int w = 0; w < 4; w++)
                roll_grid[t][w] = '0;
        beats_mode = 1'b0;
        mode_set   = 1'b0;
        end_max    = 0;
        pitch_lo   = LOW_RESET;
        pitch_hi   = 0;
        any_kept   = 1'b0;
        clip_seen  = 1'b0;
    endtask

    task automatic place_note(input logic [7:0] p, input logic [19:0] bo, input logic [19:0] bl,
                              input logic [19:0] so, input logic [19:0] sl);
        longint unsigned on_t, end_t, first, last;
        if (!mode_set)
        begin
            beats_mode = (bo != 0) || (bl != 0);
            mode_set   = 1'b1;
        end
        if (drums_off && p >= 128)
            return;
        on_t  = beats_mode ? bo : so;
        end_t = on_t + (beats_mode ? bl : sl);
        if (end_t > end_max)
            end_max = end_t;
        if (p < pitch_lo)
            pitch_lo = p;
        if (p > pitch_hi)
            pitch_hi = p;
        any_kept = 1'b1;
        first = (on_t * spu) >> 8;
        last  = (end_t * spu) >> 8;
        if (last >= MAX_STEPS)
        begin
            clip_seen = 1'b1;
            last = MAX_STEPS - 1;
        end
        for (longint unsigned t = first; t <= last && t < MAX_STEPS; t++)
            roll_grid[t][p[7:6]][p[5:0]] = 1'b1;
    endtask

    function automatic logic [63:0] fetch_slice(input int unsigned row, input int unsigned word);
        logic [63:0] bits;
        int unsigned p;
        bits = '0;
        if (!any_kept || row >= MAX_STEPS)
            return bits;
        for (int b = 0; b < 64; b++)
        begin
            p = pitch_lo + 64 * word + b;
            if (p < PITCH_SPAN && p <= pitch_hi && roll_grid[row][(p >> 6) & 3][p & 63])
                bits[b] = 1'b1;
        end
        return bits;
    endfunction

    // predict the answer for the word just accepted
    task automatic predict_word();
        roll_word_t w;
        longint unsigned steps;
        w = '0;
        if (op == OP_ADD)
            place_note(note_pitch, beat_onset, beat_length, sec_onset, sec_length);
        else if (op == OP_READ)
            w.row_bits = fetch_slice(row_index, word_index);
        else if (op == OP_CLEAR)
            clear_roll();
        if (any_kept)
        begin
            steps = ((end_max * spu + 255) >> 8) + 1;
            if (steps > MAX_STEPS)
                steps = MAX_STEPS;
            w.time_steps  = steps[10:0];
            w.pitch_count = 9'(pitch_hi - pitch_lo + 1);
        end
        w.lowest_pitch = pitch_lo[7:0];
        w.no_notes     = !any_kept;
        w.clipped      = clip_seen;
        expect_q.insert(expect_q.size(), w);
    endtask

    // valid stays high after an accept; the block leaves idle at once, so the
    // next payload or a low valid lands at the following falling edge
    task automatic send_word(input logic [1:0] o, input logic [7:0] p,
                             input logic [19:0] bo, input logic [19:0] bl,
                             input logic [19:0] so, input logic [19:0] sl,
                             input logic [9:0] r, input logic [1:0] wi);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        note_pitch  <= p;
        beat_onset  <= bo;
        beat_length <= bl;
        sec_onset   <= so;
        sec_length  <= sl;
        row_index   <= r;
        word_index  <= wi;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        predict_word();
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [6:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SPU)
            spu = val;
        else
            drums_off = val[0];
    endtask

    task automatic send_note(input logic [7:0] p, input logic [19:0] on_t, input logic [19:0] len,
                             input bit sec_only);
        send_word(OP_ADD, p, sec_only ? 20'd0 : on_t, sec_only ? 20'd0 : len, on_t, len,
                  10'd0, 2'd0);
    endtask

    task automatic send_read(input logic [9:0] r, input logic [1:0] wi);
        send_word(OP_READ, 8'd0, 20'd0, 20'd0, 20'd0, 20'd0, r, wi);
    endtask

    task automatic send_clear();
        send_word(OP_CLEAR, 8'd0, 20'd0, 20'd0, 20'd0, 20'd0, 10'd0, 2'd0);
    endtask

    // no notes yet, first note dropped as a drum still picks seconds
    task automatic test_empty_and_drums();
        send_read(10'd0, 2'd0);
        send_word(2'd3, 8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 10'h3FF, 2'd3);
        cfg_write(CFG_DROP, 7'd1);
        send_note(8'd200, 20'd256, 20'd512, 1'b1);
        send_note(8'd130, 20'd0, 20'd256, 1'b0);
        send_note(8'd60, 20'd512, 20'd256, 1'b0);
        send_read(10'd2, 2'd0);
        send_read(10'd3, 2'd1);
        send_clear();
        cfg_write(CFG_DROP, 7'd0);
    endtask

    // pitch extremes, lowest stuck at 127 with high notes, clipping, far reads
    task automatic test_extremes();
        send_note(8'd255, 20'd0, 20'd1024, 1'b0);
        send_note(8'd128, 20'd256, 20'd0, 1'b0);
        send_read(10'd0, 2'd0);
        send_read(10'd1, 2'd1);
        send_note(8'd0, 20'hFFF00, 20'hFFFFF, 1'b0);
        send_read(10'd1023, 2'd0);
        send_read(10'd1023, 2'd3);
        send_read(10'd0, 2'd3);
        send_clear();
        send_note(8'd64, 20'd0, 20'd0, 1'b1);
        send_read(10'd0, 2'd0);
        send_clear();
    endtask

    task automatic test_spu_extremes();
        cfg_write(CFG_SPU, 7'd0);
        send_note(8'd10, 20'hFFFFF, 20'hFFFFF, 1'b0);
        send_read(10'd0, 2'd0);
        cfg_write(CFG_SPU, 7'd127);
        send_note(8'd11, 20'd2048, 20'd300, 1'b0);
        send_read(10'd1000, 2'd0);
        send_clear();
    endtask

    task automatic random_items(input int n);
        logic [19:0] on_t, len;
        int unsigned r, k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
                send_clear();
            else if (k < 6)
                send_word(2'($urandom), 8'($urandom), 20'($urandom), 20'($urandom),
                          20'($urandom), 20'($urandom), 10'($urandom), 2'($urandom));
            else if (k < 55)
            begin
                if (spu == 0)
                begin
                    on_t = 20'($urandom);
                    len  = 20'($urandom);
                end
                else
                begin
                    r    = $urandom_range(0, 1040);
                    on_t = 20'((r * 256) / spu + $urandom_range(0, 255) / spu);
                    len  = 20'($urandom_range(0, (6 * 256) / spu));
                end
                recent_row = (on_t * spu) >> 8;
                send_note(8'($urandom), on_t, len, $urandom_range(0, 3) == 0);
            end
            else if (k < 90)
                send_read(10'((recent_row + $urandom_range(0, 4)) % MAX_STEPS), 2'($urandom));
            else
                send_read(10'($urandom), 2'($urandom));
        end
    endtask

    // receiver holds off while words keep coming, filling the block
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_read(10'(i), 2'd0);
        send_note(8'd33, 20'd0, 20'd512, 1'b0);
        send_read(10'd0, 2'd0);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        roll_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expect_q.size() == 0)
            begin
                $error("word with nothing expected");
                fail_cnt++;
            end
            else
            begin
                e = expect_q.pop_front();
                if (row_bits !== e.row_bits)
                begin
                    $error("row_bits exp %h got %h", e.row_bits, row_bits);
                    fail_cnt++;
                end
                if (time_steps !== e.time_steps)
                begin
                    $error("time_steps exp %0d got %0d", e.time_steps, time_steps);
                    fail_cnt++;
                end
                if (pitch_count !== e.pitch_count)
                begin
                    $error("pitch_count exp %0d got %0d", e.pitch_count, pitch_count);
                    fail_cnt++;
                end
                if (lowest_pitch !== e.lowest_pitch)
                begin
                    $error("lowest_pitch exp %0d got %0d", e.lowest_pitch, lowest_pitch);
                    fail_cnt++;
                end
                if (no_notes !== e.no_notes)
                begin
                    $error("no_notes exp %0d got %0d", e.no_notes, no_notes);
                    fail_cnt++;
                end
                if (clipped !== e.clipped)
                begin
                    $error("clipped exp %0d got %0d", e.clipped, clipped);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_ADD;
        note_pitch  = '0;
        beat_onset  = '0;
        beat_length = '0;
        sec_onset   = '0;
        sec_length  = '0;
        row_index   = '0;
        word_index  = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SPU;
        cfg_data    = '0;
        fail_cnt    = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        recent_row  = 0;
        spu         = SPU_RESET;
        drums_off   = 1'b0;
        clear_roll();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_drums();
        test_extremes();
        test_spu_extremes();
        cfg_write(CFG_SPU, 7'd4);
        random_items(500);
        test_backpressure();
        cfg_write(CFG_SPU, 7'd1);
        cfg_write(CFG_DROP, 7'd1);
        random_items(400);
        cfg_write(CFG_SPU, 7'd64);
        cfg_write(CFG_DROP, 7'd0);
        random_items(400);
        cfg_write(CFG_SPU, 7'd13);
        random_items(300);
        quiet = 1'b1;
        cfg_write(CFG_SPU, 7'd8);
        random_items(250);

        in_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_cnt == 0 && expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* piano_roll_rasterizer.f */
rtl/core/prr_pkg.sv
rtl/core/piano_roll_rasterizer.sv
bench/tb_piano_roll_rasterizer.sv
